/* hdl/assert_macros.svh */
// assertion macros shared by the histogram rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition never seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* hdl/bhtq_pkg.sv */
// types and constants shared by the byte histogram tail query block
`default_nettype none

package bhtq_pkg;

  localparam int SYMBOL_COUNT      = 256;
  localparam int COUNT_WIDTH_DEF   = 32;
  localparam int ADDR_W            = $clog2(SYMBOL_COUNT);
  localparam int LIMIT_W           = 32;
  localparam int STRIDE_W          = 16;
  localparam int OUT_W             = 32;
  localparam int CFG_DATA_W        = 32;
  localparam int CFG_IDX_W         = 1;
  localparam int IN_DATA_W         = 8;
  localparam int IN_USER_W         = 2;
  localparam int OUT_DATA_W        = 72;

  localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE      = 1'b1;

  typedef enum logic [IN_USER_W-1:0] {
    FUNC_COUNT = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_e;

  typedef struct packed {
    logic capture;
    logic acc_clr;
    logic skip_dec;
    logic cnt_upd;
    logic rd_cap;
    logic q_ref;
    logic q_scan;
    logic clear;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  skipping;
    logic  limit_hit;
    logic  scan_last;
    logic  out_free;
  } sts_t;

endpackage

`default_nettype wire

/* hdl/bhtq_ram.sv */
// generic single write port ram with registered read
`default_nettype none

module bhtq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/bhtq_datapath.sv */
// histogram store, counters, tail sum accumulator and output register
`default_nettype none

module bhtq_datapath #(
  parameter int COUNT_WIDTH = bhtq_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire bhtq_pkg::cmd_t                   cmd_i,
  output      bhtq_pkg::sts_t                   sts_o,
  input  wire logic [bhtq_pkg::IN_DATA_W-1:0]   in_data_i,
  input  wire logic [bhtq_pkg::IN_USER_W-1:0]   in_user_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [bhtq_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [bhtq_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output      logic                             out_valid_o,
  input  wire logic                             out_ready_i,
  output      logic [bhtq_pkg::OUT_W-1:0]       out_value_o,
  output      logic [bhtq_pkg::OUT_W-1:0]       out_total_o,
  output      logic                             out_counted_o,
  output      logic                             out_limit_o
);
  import bhtq_pkg::*;
  `include "assert_macros.svh"

  localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  // request fields
  func_e              func_q;
  logic [ADDR_W-1:0]  byte_q;

  // configuration
  logic [LIMIT_W-1:0]  count_limit_q;
  logic [STRIDE_W-1:0] stride_q;

  // counting state
  logic [COUNT_WIDTH-1:0] total_q, total_d;
  logic [STRIDE_W-1:0]    skip_q, skip_d;
  logic [SYMBOL_COUNT-1:0] valid_q, valid_d;
  logic                    valid_rd_q;
  logic                    counted_q, counted_d;

  // scan
  logic [COUNT_WIDTH-1:0] ref_q, ref_d;
  logic [COUNT_WIDTH-1:0] sum_q, sum_d;
  logic [ADDR_W-1:0]      scan_addr_q, scan_addr_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic [OUT_W-1:0]   out_value_q, out_total_q;
  logic               out_counted_q, out_limit_q;

  // ram
  logic [ADDR_W-1:0]      rd_addr;
  logic [COUNT_WIDTH-1:0] ram_rdata;
  logic [COUNT_WIDTH-1:0] bin_val;
  logic [COUNT_WIDTH-1:0] bin_inc;
  logic [COUNT_WIDTH:0]   sum_wide;
  logic [COUNT_WIDTH-1:0] sum_sat;
  logic                   take;
  logic                   limit_hit;

  bhtq_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (SYMBOL_COUNT)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (cmd_i.cnt_upd),
    .waddr_i (byte_q),
    .wdata_i (bin_inc),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (cmd_i.q_scan) begin
      rd_addr = scan_addr_q + ADDR_W'(1);
    end else if (cmd_i.q_ref) begin
      rd_addr = '0;
    end else begin
      rd_addr = byte_q;
    end
  end

  // a bin never written since the last clear reads as zero
  assign bin_val   = valid_rd_q ? ram_rdata : '0;
  assign bin_inc   = (bin_val == CNT_MAX) ? bin_val : bin_val + COUNT_WIDTH'(1);
  assign sum_wide  = {1'b0, sum_q} + {1'b0, bin_val};
  assign sum_sat   = sum_wide[COUNT_WIDTH] ? CNT_MAX : sum_wide[COUNT_WIDTH-1:0];
  assign take      = (scan_addr_q == byte_q) || (bin_val <= ref_q);
  assign limit_hit = (count_limit_q != '0) &&
                     (CMP_W'(total_q) >= CMP_W'(count_limit_q));

  always_comb begin
    total_d     = total_q;
    skip_d      = skip_q;
    valid_d     = valid_q;
    counted_d   = counted_q;
    ref_d       = ref_q;
    sum_d       = sum_q;
    scan_addr_d = scan_addr_q;
    if (cmd_i.acc_clr) begin
      sum_d     = '0;
      counted_d = 1'b0;
    end
    if (cmd_i.skip_dec) begin
      skip_d = skip_q - STRIDE_W'(1);
    end
    if (cmd_i.cnt_upd) begin
      valid_d[byte_q] = 1'b1;
      total_d   = (total_q == CNT_MAX) ? total_q : total_q + COUNT_WIDTH'(1);
      skip_d    = (stride_q > STRIDE_W'(1)) ? stride_q - STRIDE_W'(1) : '0;
      counted_d = 1'b1;
    end
    if (cmd_i.rd_cap) begin
      sum_d = bin_val;
    end
    if (cmd_i.q_ref) begin
      ref_d       = bin_val;
      sum_d       = '0;
      scan_addr_d = '0;
    end
    if (cmd_i.q_scan) begin
      if (take) begin
        sum_d = sum_sat;
      end
      scan_addr_d = scan_addr_q + ADDR_W'(1);
    end
    if (cmd_i.clear) begin
      valid_d = '0;
      total_d = '0;
      skip_d  = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_limit_q <= '0;
      stride_q      <= STRIDE_W'(1);
      total_q       <= '0;
      skip_q        <= '0;
      valid_q       <= '0;
      valid_rd_q    <= 1'b0;
      counted_q     <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_COUNT_LIMIT: count_limit_q <= cfg_data_i[LIMIT_W-1:0];
          REG_STRIDE:      stride_q      <= cfg_data_i[STRIDE_W-1:0];
          default: ;
        endcase
      end
      total_q     <= total_d;
      skip_q      <= skip_d;
      valid_q     <= valid_d;
      valid_rd_q  <= valid_q[rd_addr];
      counted_q   <= counted_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_e'(in_user_i);
      byte_q <= in_data_i[ADDR_W-1:0];
    end
    ref_q       <= ref_d;
    sum_q       <= sum_d;
    scan_addr_q <= scan_addr_d;
    if (cmd_i.load_out) begin
      out_value_q   <= OUT_W'(sum_q);
      out_total_q   <= OUT_W'(total_q);
      out_counted_q <= counted_q;
      out_limit_q   <= limit_hit;
    end
  end

  assign sts_o.func      = func_q;
  assign sts_o.skipping  = (skip_q != '0);
  assign sts_o.limit_hit = limit_hit;
  assign sts_o.scan_last = (scan_addr_q == ADDR_W'(SYMBOL_COUNT - 1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign out_value_o   = out_value_q;
  assign out_total_o   = out_total_q;
  assign out_counted_o = out_counted_q;
  assign out_limit_o   = out_limit_q;

  `ASSERT_PROP(a_total_no_drop, !cmd_i.clear |=> total_q >= $past(total_q), "total went down without a clear")
  `ASSERT_NEVER(a_load_over_full, cmd_i.load_out && out_valid_q && !out_ready_i, "result register overwritten")
  `ASSERT_PROP(a_skip_only_when_skipping, cmd_i.skip_dec |-> skip_q != '0, "skip counter underflow")

endmodule

`default_nettype wire

/* hdl/bhtq_ctrl.sv */
// sequencer for count, read, tail query and clear requests
`default_nettype none

module bhtq_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output      logic           in_ready_o,
  output      bhtq_pkg::cmd_t cmd_o,
  input  wire bhtq_pkg::sts_t sts_i
);
  import bhtq_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CNT_UPD,
    ST_RD_CAP,
    ST_Q_REF,
    ST_Q_SCAN,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.acc_clr = 1'b1;
        case (sts_i.func)
          FUNC_COUNT: begin
            if (sts_i.skipping) begin
              cmd_o.skip_dec = 1'b1;
              state_d        = ST_FINISH;
            end else if (sts_i.limit_hit) begin
              state_d = ST_FINISH;
            end else begin
              state_d = ST_CNT_UPD;
            end
          end
          FUNC_READ:  state_d = ST_RD_CAP;
          FUNC_QUERY: state_d = ST_Q_REF;
          FUNC_CLEAR: begin
            cmd_o.clear = 1'b1;
            state_d     = ST_FINISH;
          end
          default: state_d = ST_FINISH;
        endcase
      end
      ST_CNT_UPD: begin
        cmd_o.cnt_upd = 1'b1;
        state_d       = ST_FINISH;
      end
      ST_RD_CAP: begin
        cmd_o.rd_cap = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_Q_REF: begin
        cmd_o.q_ref = 1'b1;
        state_d     = ST_Q_SCAN;
      end
      ST_Q_SCAN: begin
        cmd_o.q_scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `ASSERT_PROP(a_one_action, $onehot0({cmd_o.cnt_upd, cmd_o.rd_cap, cmd_o.q_ref, cmd_o.q_scan, cmd_o.clear, cmd_o.load_out}), "more than one datapath action")
  `ASSERT_PROP(a_load_when_free, cmd_o.load_out |-> sts_i.out_free, "result loaded while register busy")
  `ASSERT_PROP(a_ref_then_scan, cmd_o.q_ref |=> cmd_o.q_scan, "tail scan did not follow reference read")

endmodule

`default_nettype wire

/* hdl/byte_histogram_tail_query.sv */
// Byte histogram with stride, window limit, bin read and tail query.
//
// Requests enter on s_axis: tuser carries the function (count byte, read
// bin, tail query, clear) and tdata the byte or bin. One result per request
// leaves on m_axis with the bin value or tail sum, the total counted since
// the last clear, a counted flag and a limit flag.
// One request is handled at a time. A count or a read passes through the
// decode state, its update or read state and the finish state, where its
// result is loaded; a clear, or a count that is skipped or dropped, goes
// from decode straight to finish. A tail query reads the reference bin and
// then walks all 256 bins through the single read port of the bin ram, one
// bin per cycle, before its result is loaded. The next request is taken
// the cycle after a result is loaded, while that result may still wait on
// m_axis. A stalled m_axis holds its result; a finished request then waits
// until the output register is free.
// Reset empties the histogram at once through per-bin valid flags, clears
// the total and the skip counter, sets count_limit to 0 and stride to 1.
// The user must make configuration writes through cfg_we_i only while no
// request is in flight; the block itself does not enforce this.
`default_nettype none

module byte_histogram_tail_query #(
  parameter int COUNT_WIDTH = bhtq_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output      logic                              s_axis_tready,
  input  wire logic [bhtq_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // data_byte
  input  wire logic [bhtq_pkg::IN_USER_W-1:0]    s_axis_tuser,  // func
  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // value, total, counted, limit_reached, zero pad
  output      logic [bhtq_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  wire logic                              cfg_we_i,
  input  wire logic [bhtq_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [bhtq_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import bhtq_pkg::*;

  localparam int PAD_W = OUT_DATA_W - 2 * OUT_W - 2;

  cmd_t             cmd;
  sts_t             sts;
  logic [OUT_W-1:0] out_value;
  logic [OUT_W-1:0] out_total;
  logic             out_counted;
  logic             out_limit;

  bhtq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  bhtq_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_data_i     (s_axis_tdata),
    .in_user_i     (s_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_value_o   (out_value),
    .out_total_o   (out_total),
    .out_counted_o (out_counted),
    .out_limit_o   (out_limit)
  );

  assign m_axis_tdata = {{PAD_W{1'b0}}, out_limit, out_counted, out_total, out_value};

endmodule

`default_nettype wire
